>>> src/wsh_pkg.sv
// Shared constants, codes and tables of the multi-mode waveshaper.
package wsh_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 12;
   localparam int FRAC      = SAMPLE_W - 1;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int A_W       = 27;   // gained magnitude, at most 2^27 - 1
   localparam int SHAPED_W  = 32;   // square mode stays below 2^31

   localparam logic [CSR_IDX_W-1:0] REG_IN_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 2'd2;

   localparam logic [MODE_W-1:0] MODE_HARD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SOFT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EXP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FULL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HALF   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam int          EXP_TERMS = 13;
   localparam int          K_W       = 5;    // range reduction count, at most 23

   // reciprocals ceil(2^sh / n) for the Horner divisors n = 13 down to 1
   localparam logic [32:0] RECIP_M [EXP_TERMS] = '{
      33'd5286113596, 33'd5726623062, 33'd6247225158, 33'd6871947674,
      33'd7635497416, 33'd4294967296, 33'd4908534053, 33'd5726623062,
      33'd6871947674, 33'd4294967296, 33'd5726623062, 33'd4294967296,
      33'd4294967296};
   localparam int RECIP_SH [EXP_TERMS] = '{
      36, 36, 36, 36, 36, 35, 35, 35, 35, 34, 34, 33, 32};

   // reciprocal of 6 for 24-bit dividends
   localparam logic [24:0] RECIP6_M  = 25'd22369622;
   localparam int          RECIP6_SH = 27;

   localparam int FRONT_LAT = 3;                      // input, gain product, magnitude
   localparam int EXP_LAT   = 3 + 3 * EXP_TERMS + 1;  // divide, Horner, final shift
   localparam int ALT_LAT   = 5;
   localparam int ALT_DELAY = EXP_LAT - ALT_LAT;
   localparam int LATENCY   = FRONT_LAT + EXP_LAT + 2;

endpackage

>>> src/multi_mode_waveshaper.sv
// Pipelined waveshaper: input gain, one of six curves, output gain, saturation.
//
// Takes one sample in every clock cycle (busy stays low) and marks each result
// with a one-cycle rsp_valid strobe; results cannot be held off. The latency is
// set by the exponential curve: a five-step range reduction by ln2 and a 13-term
// Horner series, each term one multiply, one reciprocal multiply and one subtract
// stage. All other curves run in a short side pipeline and are delayed to match.
// Write the registers only while no transaction is in flight.
module multi_mode_waveshaper
   import wsh_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_saturated,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [GAIN_W-1:0]          csr_wdata
);

   localparam logic [1:0] SOFT_LIN   = 2'd0;
   localparam logic [1:0] SOFT_CURVE = 2'd1;
   localparam logic [1:0] SOFT_FLAT  = 2'd2;

   localparam logic [A_W-1:0]  HALF_A  = A_W'(1) << (FRAC - 1);
   localparam logic [32:0]     ONE_Q32 = 33'h1_0000_0000;

   typedef struct packed {
      logic [31:0]    r;
      logic [K_W-1:0] k;
   } exp_carry_type;

   typedef struct packed {
      logic                neg;
      logic [SHAPED_W-1:0] val;
   } alt_type;

   // configuration
   logic [GAIN_W-1:0] in_gain_ff, out_gain_ff;
   logic [MODE_W-1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_gain_ff  <= GAIN_UNITY;
         out_gain_ff <= GAIN_UNITY;
         mode_ff     <= MODE_HARD;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IN_GAIN:  in_gain_ff  <= csr_wdata;
            REG_OUT_GAIN: out_gain_ff <= csr_wdata;
            REG_MODE:     mode_ff     <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // front: register, gain product, rounded magnitude
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                mul_valid_ff, mul_neg_ff;
   logic [39:0]         mul_prod_ff;
   logic                a_valid_ff, a_neg_ff;
   logic [A_W-1:0]      a_ff;

   logic [SAMPLE_W-1:0] mag;
   logic [A_W-1:0]      a_in;

   always_comb begin
      mag  = in_sample_ff[SAMPLE_W-1] ? (~in_sample_ff + SAMPLE_W'(1)) : in_sample_ff;
      a_in = A_W'((mul_prod_ff + 40'd2048) >> GAIN_FRAC);
   end

   always_ff @(posedge clock) begin
      in_sample_ff <= req_sample_in;
      mul_prod_ff  <= 40'(mag) * 40'(in_gain_ff);
      mul_neg_ff   <= in_sample_ff[SAMPLE_W-1];
      a_ff         <= a_in;
      a_neg_ff     <= mul_neg_ff && (a_in != '0);
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         mul_valid_ff <= in_valid_ff;
         a_valid_ff   <= mul_valid_ff;
      end
   end

   // side pipeline: hard clip, soft clip, rectifiers, square
   logic                c1_valid_ff, c2_valid_ff, c3_valid_ff, c4_valid_ff;
   logic                c1_neg_ff, c2_neg_ff, c3_neg_ff, c4_neg_ff;
   logic [A_W-1:0]      c1_a_ff, c2_a_ff, c3_a_ff, c4_a_ff;
   logic [A_W-1:0]      c1_hard_ff, c2_hard_ff, c3_hard_ff, c4_hard_ff;
   logic [1:0]          c1_sel_ff, c2_sel_ff, c3_sel_ff, c4_sel_ff;
   logic [23:0]         c1_d_ff;
   logic [53:0]         c1_sq_ff;
   logic [47:0]         c2_dd_ff;
   logic [SHAPED_W-1:0] c2_sq_ff, c3_sq_ff, c4_sq_ff;
   logic [24:0]         c3_v_ff;
   logic [49:0]         c4_vm_ff;
   logic                alt_valid_ff;
   alt_type             alt_ff;

   logic [28:0]         t3;
   logic [1:0]          sel_in;
   logic [A_W-1:0]      soft_val;
   alt_type             alt_in;

   always_comb begin
      t3 = 29'(a_ff) * 29'd3;
      if (t3 > (29'(1) << (FRAC + 1)))  sel_in = SOFT_FLAT;
      else if (t3 > (29'(1) << FRAC))   sel_in = SOFT_CURVE;
      else                              sel_in = SOFT_LIN;

      case (c4_sel_ff)
         SOFT_FLAT:  soft_val = HALF_A;
         SOFT_CURVE: soft_val = HALF_A - A_W'(c4_vm_ff >> RECIP6_SH);
         default:    soft_val = c4_a_ff;
      endcase

      alt_in = '0;
      case (mode_ff)
         MODE_HARD:   alt_in = '{neg: c4_neg_ff, val: SHAPED_W'(c4_hard_ff)};
         MODE_SOFT:   alt_in = '{neg: c4_neg_ff, val: SHAPED_W'(soft_val)};
         MODE_EXP:    alt_in = '{neg: c4_neg_ff, val: '0};
         MODE_FULL:   alt_in = '{neg: 1'b0, val: SHAPED_W'(c4_a_ff)};
         MODE_HALF:   alt_in = '{neg: 1'b0,
                                 val: c4_neg_ff ? '0 : SHAPED_W'(c4_a_ff)};
         MODE_SQUARE: alt_in = '{neg: 1'b0, val: c4_sq_ff};
         default:     alt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      c1_neg_ff  <= a_neg_ff;
      c1_a_ff    <= a_ff;
      c1_hard_ff <= (a_ff > HALF_A) ? HALF_A : a_ff;
      c1_sel_ff  <= sel_in;
      c1_d_ff    <= 24'((29'(1) << (FRAC + 1)) - t3);
      c1_sq_ff   <= 54'(a_ff) * 54'(a_ff);

      c2_neg_ff  <= c1_neg_ff;
      c2_a_ff    <= c1_a_ff;
      c2_hard_ff <= c1_hard_ff;
      c2_sel_ff  <= c1_sel_ff;
      c2_dd_ff   <= 48'(c1_d_ff) * 48'(c1_d_ff);
      c2_sq_ff   <= SHAPED_W'((c1_sq_ff + (54'(1) << (FRAC - 1))) >> FRAC);

      c3_neg_ff  <= c2_neg_ff;
      c3_a_ff    <= c2_a_ff;
      c3_hard_ff <= c2_hard_ff;
      c3_sel_ff  <= c2_sel_ff;
      c3_sq_ff   <= c2_sq_ff;
      c3_v_ff    <= 25'((c2_dd_ff + (48'd3 << FRAC)) >> FRAC);

      c4_neg_ff  <= c3_neg_ff;
      c4_a_ff    <= c3_a_ff;
      c4_hard_ff <= c3_hard_ff;
      c4_sel_ff  <= c3_sel_ff;
      c4_sq_ff   <= c3_sq_ff;
      c4_vm_ff   <= 50'(c3_v_ff) * 50'(RECIP6_M);

      alt_ff     <= alt_in;
      if (reset) begin
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         c3_valid_ff  <= 1'b0;
         c4_valid_ff  <= 1'b0;
         alt_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff  <= a_valid_ff;
         c2_valid_ff  <= c1_valid_ff;
         c3_valid_ff  <= c2_valid_ff;
         c4_valid_ff  <= c3_valid_ff;
         alt_valid_ff <= c4_valid_ff;
      end
   end

   // delay line to meet the exponential path
   logic [ALT_DELAY-1:0] line_valid_ff;
   alt_type              line_ff [ALT_DELAY];

   always_ff @(posedge clock) begin
      line_ff[0] <= alt_ff;
      for (int j = 1; j < ALT_DELAY; j++) begin
         line_ff[j] <= line_ff[j-1];
      end
      if (reset) begin
         line_valid_ff <= '0;
      end else begin
         line_valid_ff <= {line_valid_ff[ALT_DELAY-2:0], alt_valid_ff};
      end
   end

   // exponential: range reduction a = k ln2 + r
   logic [35:0]    d1_rem_ff, d2_rem_ff, d3_rem_ff;
   logic [K_W-1:0] d1_k_ff, d2_k_ff, d3_k_ff;
   logic [35:0]    d1_rem, d2_rem, d3_rem;
   logic [K_W-1:0] d1_k, d2_k, d3_k;

   always_comb begin
      d1_rem = {a_ff, 9'b0};
      d1_k   = '0;
      for (int j = 4; j >= 3; j--) begin
         if (d1_rem >= (36'(LN2_Q32) << j)) begin
            d1_rem  = d1_rem - (36'(LN2_Q32) << j);
            d1_k[j] = 1'b1;
         end
      end
      d2_rem = d1_rem_ff;
      d2_k   = d1_k_ff;
      for (int j = 2; j >= 1; j--) begin
         if (d2_rem >= (36'(LN2_Q32) << j)) begin
            d2_rem  = d2_rem - (36'(LN2_Q32) << j);
            d2_k[j] = 1'b1;
         end
      end
      d3_rem = d2_rem_ff;
      d3_k   = d2_k_ff;
      if (d3_rem >= 36'(LN2_Q32)) begin
         d3_rem  = d3_rem - 36'(LN2_Q32);
         d3_k[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      d1_rem_ff <= d1_rem;
      d1_k_ff   <= d1_k;
      d2_rem_ff <= d2_rem;
      d2_k_ff   <= d2_k;
      d3_rem_ff <= d3_rem;
      d3_k_ff   <= d3_k;
   end

   // Horner series of e^-r, one term per three stages
   logic [31:0]   hq_ff  [EXP_TERMS];
   logic [64:0]   hqm_ff [EXP_TERMS];
   logic [32:0]   hp_ff  [EXP_TERMS];
   exp_carry_type car_q_ff [EXP_TERMS];
   exp_carry_type car_m_ff [EXP_TERMS];
   exp_carry_type car_p_ff [EXP_TERMS];
   logic [32:0]   p_src   [EXP_TERMS];
   exp_carry_type car_src [EXP_TERMS];
   logic [64:0]   rp      [EXP_TERMS];

   always_comb begin
      for (int i = 0; i < EXP_TERMS; i++) begin
         if (i == 0) begin
            p_src[i]   = ONE_Q32;
            car_src[i] = '{r: d3_rem_ff[31:0], k: d3_k_ff};
         end else begin
            p_src[i]   = hp_ff[i-1];
            car_src[i] = car_p_ff[i-1];
         end
         rp[i] = 65'(car_src[i].r) * 65'(p_src[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < EXP_TERMS; i++) begin
         hq_ff[i]    <= rp[i][63:32];
         car_q_ff[i] <= car_src[i];
         hqm_ff[i]   <= 65'(hq_ff[i]) * 65'(RECIP_M[i]);
         car_m_ff[i] <= car_q_ff[i];
         hp_ff[i]    <= ONE_Q32 - 33'(hqm_ff[i] >> RECIP_SH[i]);
         car_p_ff[i] <= car_m_ff[i];
      end
   end

   // scale by 2^-k, round to sample precision, take 1 - e^-a
   logic [SAMPLE_W-1:0] exp_ff;
   logic [32:0]         e32;
   logic [SAMPLE_W-1:0] e_rnd;

   always_comb begin
      e32   = hp_ff[EXP_TERMS-1] >> car_p_ff[EXP_TERMS-1].k;
      e_rnd = SAMPLE_W'((34'(e32) + 34'd256) >> (32 - FRAC));
   end

   always_ff @(posedge clock) begin
      exp_ff <= (SAMPLE_W'(1) << FRAC) - e_rnd;
   end

   // output gain, rounding and saturation
   alt_type             tail;
   logic [SHAPED_W-1:0] shaped;
   logic                g1_valid_ff, g1_neg_ff;
   logic [47:0]         g1_prod_ff;
   logic [35:0]         res;
   logic                res_neg;
   logic [SAMPLE_W-1:0] out_val;
   logic                out_sat;
   logic                rsp_valid_ff, rsp_saturated_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;

   always_comb begin
      tail   = line_ff[ALT_DELAY-1];
      shaped = (mode_ff == MODE_EXP) ? SHAPED_W'(exp_ff) : tail.val;

      res     = 36'((g1_prod_ff + 48'd2048) >> GAIN_FRAC);
      res_neg = g1_neg_ff && (res != '0);
      out_sat = 1'b0;
      if (res_neg) begin
         if (res > (36'(1) << FRAC)) begin
            out_val = SAMPLE_W'(1) << FRAC;
            out_sat = 1'b1;
         end else begin
            out_val = SAMPLE_W'(36'(0) - res);
         end
      end else begin
         if (res > ((36'(1) << FRAC) - 36'(1))) begin
            out_val = (SAMPLE_W'(1) << FRAC) - SAMPLE_W'(1);
            out_sat = 1'b1;
         end else begin
            out_val = SAMPLE_W'(res);
         end
      end
   end

   always_ff @(posedge clock) begin
      g1_prod_ff       <= 48'(shaped) * 48'(out_gain_ff);
      g1_neg_ff        <= tail.neg;
      rsp_sample_ff    <= out_val;
      rsp_saturated_ff <= out_sat;
      if (reset) begin
         g1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         g1_valid_ff  <= line_valid_ff[ALT_DELAY-1];
         rsp_valid_ff <= g1_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_saturated_ff;

endmodule

>>> src/wsh_checker.sv
// Port-level assertions of the waveshaper and their binding.
module wsh_checker
   import wsh_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic signed [SAMPLE_W-1:0] req_sample_in,
   input logic                       rsp_valid,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_saturated
);

   // every transaction comes back after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result missing after start");

   // no result without a transaction that started it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction");

   // a clamp leaves the sample at one of the two range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_sample_out == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
         rsp_sample_out == {1'b1, {(SAMPLE_W-1){1'b0}}})
      else $error("saturated flag with unclamped sample");

   // the zero input of any curve stays zero
   a_zero_in: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_sample_in == '0 |->
         ##LATENCY rsp_sample_out == '0 && !rsp_saturated)
      else $error("zero sample gave nonzero result");

endmodule

bind multi_mode_waveshaper wsh_checker u_wsh_checker (.*);
